@@ design/swas_pkg.sv @@
// Shared types, codes and elaboration helpers for the stop-and-wait ARQ sender.
package swas_pkg;

  // Operation codes carried on s_tuser
  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_ACK    = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_CHUNK_SIZE = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd1;

  // What the transmit sequencer is asked to produce for one input transaction.
  typedef enum logic [1:0] {
    CMD_ONE   = 2'd0,
    CMD_FRAME = 2'd1,
    CMD_END   = 2'd2
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_STORED     = 3'd0,
    ST_SENT       = 3'd1,
    ST_RESENT     = 3'd2,
    ST_DELIVERED  = 3'd3,
    ST_UNEXPECTED = 3'd4,
    ST_IGNORED    = 3'd5
  } status_t;

  typedef struct packed {
    cmd_kind_t   kind;
    status_t     status;
    logic [15:0] attempt;
    logic        seq;
  } swas_cmd_t;

  // Decimal digits needed for the largest value v.
  function automatic int num_digits(input int v);
    int n;
    int r;
    n = 1;
    r = v;
    while (r >= 10) begin
      r = r / 10;
      n++;
    end
    return n;
  endfunction

  function automatic int pow10(input int k);
    int p;
    case (k)
      0:       p = 1;
      1:       p = 10;
      2:       p = 100;
      3:       p = 1000;
      4:       p = 10000;
      default: p = 1;
    endcase
    return p;
  endfunction

endpackage

@@ design/swas_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module swas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/swas_dec.sv @@
// Iterative binary to decimal converter: one compare and subtract per cycle.
module swas_dec #(
  parameter int SUM_W = 11,
  parameter int NDIG  = 4,
  parameter int DIG_W = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [SUM_W-1:0]           value,
  output logic                       done,
  output logic [NDIG-1:0][3:0]       digits,
  output logic [DIG_W-1:0]           lead
);

  import swas_pkg::*;

  logic             running;
  logic [SUM_W-1:0] rem;
  logic [DIG_W-1:0] k;
  logic [3:0]       digit;
  logic             seen;
  logic [SUM_W-1:0] pow_k;
  logic             ge;
  logic             finish_last;

  assign pow_k       = SUM_W'(pow10(int'(k)));
  assign ge          = (rem >= pow_k);
  assign finish_last = !ge && (k == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && finish_last) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= value;
      k     <= DIG_W'(NDIG - 1);
      digit <= 4'd0;
      seen  <= 1'b0;
    end else if (running) begin
      if (ge) begin
        rem   <= rem - pow_k;
        digit <= digit + 4'd1;
      end else begin
        digits[k] <= digit;
        digit     <= 4'd0;
        // first non-zero position from the top sets the leading digit
        if (!seen && ((digit != 4'd0) || (k == '0))) begin
          lead <= k;
          seen <= 1'b1;
        end
        if (k != '0) begin
          k <= k - DIG_W'(1);
        end
      end
    end
  end

endmodule

@@ design/swas_tx.sv @@
// Transmit sequencer: walks the frame sections and feeds the output register.
module swas_tx #(
  parameter int FILL_W = 4,
  parameter int SUM_W  = 11,
  parameter int IDX_W  = 3,
  parameter int NDIG   = 4,
  parameter int DIG_W  = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  swas_pkg::swas_cmd_t  cmd,
  input  logic [FILL_W-1:0]    fill,
  input  logic [SUM_W-1:0]     sum,
  output logic                 busy,
  output logic                 ram_re,
  output logic [IDX_W-1:0]     ram_raddr,
  input  logic [7:0]           ram_rdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,  // tx_byte[7:0], attempt[23:8]
  output logic [3:0]           m_tuser,  // byte_valid[0], status[3:1]
  output logic                 m_tlast   // last_of_run
);

  import swas_pkg::*;

  localparam int CNT_W = (FILL_W > 3) ? FILL_W : 3;

  localparam logic [7:0] CH_D   = 8'h44;
  localparam logic [7:0] CH_A   = 8'h41;
  localparam logic [7:0] CH_T   = 8'h54;
  localparam logic [7:0] CH_E   = 8'h45;
  localparam logic [7:0] CH_N   = 8'h4E;
  localparam logic [7:0] CH_BAR = 8'h7C;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_0   = 8'h30;

  typedef enum logic [10:0] {
    T_IDLE = 11'b000_0000_0001,
    T_CONV = 11'b000_0000_0010,
    T_HEAD = 11'b000_0000_0100,
    T_SEQ  = 11'b000_0000_1000,
    T_BAR1 = 11'b000_0001_0000,
    T_PAY  = 11'b000_0010_0000,
    T_BAR2 = 11'b000_0100_0000,
    T_DIG  = 11'b000_1000_0000,
    T_NL   = 11'b001_0000_0000,
    T_END  = 11'b010_0000_0000,
    T_ONE  = 11'b100_0000_0000
  } tx_state_t;

  tx_state_t          state;
  tx_state_t          state_next;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  swas_cmd_t          cmd_q;
  logic [FILL_W-1:0]  fill_q;

  logic               dec_start;
  logic               dec_done;
  logic [NDIG-1:0][3:0] dec_digits;
  logic [DIG_W-1:0]   dec_lead;

  logic               emitting;
  logic               adv;
  logic               last_pay;
  logic [7:0]         byte_sel;
  logic               bvalid_sel;
  logic               last_sel;

  logic [7:0]         out_byte;
  logic               out_bv;
  status_t            out_status;
  logic [15:0]        out_attempt;
  logic               out_last;

  function automatic logic [7:0] head_byte(input logic [CNT_W-1:0] i);
    logic [7:0] b;
    case (i)
      CNT_W'(0): b = CH_D;
      CNT_W'(1): b = CH_A;
      CNT_W'(2): b = CH_T;
      CNT_W'(3): b = CH_A;
      default:   b = CH_BAR;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] end_byte(input logic [CNT_W-1:0] i);
    logic [7:0] b;
    case (i)
      CNT_W'(0): b = CH_E;
      CNT_W'(1): b = CH_N;
      CNT_W'(2): b = CH_D;
      default:   b = CH_NL;
    endcase
    return b;
  endfunction

  swas_dec #(
    .SUM_W (SUM_W),
    .NDIG  (NDIG),
    .DIG_W (DIG_W)
  ) u_dec (
    .clk    (clk),
    .rst    (rst),
    .start  (dec_start),
    .value  (sum),
    .done   (dec_done),
    .digits (dec_digits),
    .lead   (dec_lead)
  );

  assign busy      = (state != T_IDLE);
  assign dec_start = start && (state == T_IDLE) && (cmd.kind == CMD_FRAME);
  assign emitting  = (state != T_IDLE) && (state != T_CONV);
  assign adv       = emitting && (!m_tvalid || m_tready);
  assign last_pay  = (cnt == CNT_W'(fill_q - FILL_W'(1)));

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    byte_sel   = 8'd0;
    bvalid_sel = 1'b1;
    last_sel   = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    unique case (state)
      T_IDLE: begin
        bvalid_sel = 1'b0;
        if (start) begin
          cnt_next = '0;
          unique case (cmd.kind)
            CMD_FRAME: state_next = T_CONV;
            CMD_END:   state_next = T_END;
            default:   state_next = T_ONE;
          endcase
        end
      end
      T_CONV: begin
        bvalid_sel = 1'b0;
        if (dec_done) begin
          state_next = T_HEAD;
          cnt_next   = '0;
        end
      end
      T_HEAD: begin
        byte_sel = head_byte(cnt);
        if (adv) begin
          if (cnt == CNT_W'(4)) begin
            state_next = T_SEQ;
          end else begin
            cnt_next = cnt + CNT_W'(1);
          end
        end
      end
      T_SEQ: begin
        byte_sel = CH_0 + {7'd0, cmd_q.seq};
        if (adv) begin
          state_next = T_BAR1;
        end
      end
      T_BAR1: begin
        byte_sel = CH_BAR;
        // prefetch the first payload byte
        if (adv) begin
          ram_re     = 1'b1;
          ram_raddr  = '0;
          state_next = T_PAY;
          cnt_next   = '0;
        end
      end
      T_PAY: begin
        byte_sel = ram_rdata;
        if (adv) begin
          if (last_pay) begin
            state_next = T_BAR2;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = IDX_W'(cnt + CNT_W'(1));
            cnt_next  = cnt + CNT_W'(1);
          end
        end
      end
      T_BAR2: begin
        byte_sel = CH_BAR;
        if (adv) begin
          state_next = T_DIG;
          cnt_next   = CNT_W'(dec_lead);
        end
      end
      T_DIG: begin
        byte_sel = CH_0 + {4'd0, dec_digits[cnt[DIG_W-1:0]]};
        if (adv) begin
          if (cnt == '0) begin
            state_next = T_NL;
          end else begin
            cnt_next = cnt - CNT_W'(1);
          end
        end
      end
      T_NL: begin
        byte_sel = CH_NL;
        last_sel = 1'b1;
        if (adv) begin
          state_next = T_IDLE;
        end
      end
      T_END: begin
        byte_sel = end_byte(cnt);
        last_sel = (cnt == CNT_W'(3));
        if (adv) begin
          if (cnt == CNT_W'(3)) begin
            state_next = T_IDLE;
          end else begin
            cnt_next = cnt + CNT_W'(1);
          end
        end
      end
      T_ONE: begin
        bvalid_sel = 1'b0;
        last_sel   = 1'b1;
        if (adv) begin
          state_next = T_IDLE;
        end
      end
      default: begin
        state_next = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    if ((state == T_IDLE) && start) begin
      cmd_q  <= cmd;
      fill_q <= fill;
    end
    if (adv) begin
      out_byte    <= bvalid_sel ? byte_sel : 8'd0;
      out_bv      <= bvalid_sel;
      out_status  <= cmd_q.status;
      out_attempt <= cmd_q.attempt;
      out_last    <= last_sel;
    end
  end

  assign m_tdata = {out_attempt, out_byte};
  assign m_tuser = {out_status, out_bv};
  assign m_tlast = out_last;

endmodule

@@ design/stop_and_wait_arq_sender_top.sv @@
// Stop-and-wait ARQ sender: protocol state, chunk store and transmit sequencer.
// An item that gives one result: s_tready drops until the result is loaded into the
//   output register, so the next item is not taken until that result is registered.
// A frame: the byte sum is converted to decimal first on the iterative compare/subtract unit,
//   then 9 + fill + digits bytes leave one per cycle while the output is not stalled; END is 4.
// Output stalls hold s_tready low. Reset (rst high) clears control state, not the store.
module stop_and_wait_arq_sender_top #(
  parameter int CHUNK_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // payload_byte[7:0], ack_seq[15:8]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  input  logic        s_tlast,   // end_of_message
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // tx_byte[7:0], attempt[23:8]
  output logic [3:0]  m_tuser,   // byte_valid[0], status[3:1]
  output logic        m_tlast    // last_of_run
);

  import swas_pkg::*;

  localparam int FILL_W = $clog2(CHUNK_BYTES + 1);
  localparam int SUM_W  = $clog2(CHUNK_BYTES * 255 + 1);
  localparam int IDX_W  = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam int NDIG   = num_digits(CHUNK_BYTES * 255);
  localparam int DIG_W  = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int LIM_W  = (FILL_W > 4) ? FILL_W : 4;

  // configuration
  logic [3:0]        chunk_size;
  logic [15:0]       timeout_ticks;

  // protocol state
  logic [FILL_W-1:0] fill_count,    fill_count_next;
  logic              seq_bit,       seq_bit_next;
  logic              awaiting_ack,  awaiting_ack_next;
  logic              final_chunk,   final_chunk_next;
  logic [SUM_W-1:0]  byte_sum,      byte_sum_next;
  logic [15:0]       tick_count,    tick_count_next;
  logic [15:0]       attempt_count, attempt_count_next;

  logic              accept;
  logic              tx_busy;
  logic              store_we;
  swas_cmd_t         cmd;

  logic [7:0]        payload_byte;
  logic [7:0]        ack_seq;
  logic [1:0]        operation;
  logic              end_of_message;

  logic [LIM_W-1:0]  chunk_limit;
  logic [15:0]       tick_limit;
  logic [15:0]       tick_inc;
  logic [15:0]       attempt_inc;

  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [7:0]        ram_rdata;

  assign payload_byte   = s_tdata[7:0];
  assign ack_seq        = s_tdata[15:8];
  assign operation      = s_tuser;
  assign end_of_message = s_tlast;

  // one input transaction at a time: taken only while the sequencer is free
  assign s_tready  = !tx_busy;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // chunk size clamped to 1..CHUNK_BYTES, timeout of zero acts as one
  always_comb begin
    if (chunk_size == 4'd0) begin
      chunk_limit = LIM_W'(1);
    end else if (LIM_W'(chunk_size) > LIM_W'(CHUNK_BYTES)) begin
      chunk_limit = LIM_W'(CHUNK_BYTES);
    end else begin
      chunk_limit = LIM_W'(chunk_size);
    end
  end

  assign tick_limit  = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
  assign tick_inc    = (tick_count == 16'hFFFF) ? tick_count : tick_count + 16'd1;
  assign attempt_inc = (attempt_count == 16'hFFFF) ? attempt_count : attempt_count + 16'd1;

  // next protocol state and the command for the transmit side
  always_comb begin
    fill_count_next    = fill_count;
    seq_bit_next       = seq_bit;
    awaiting_ack_next  = awaiting_ack;
    final_chunk_next   = final_chunk;
    byte_sum_next      = byte_sum;
    tick_count_next    = tick_count;
    attempt_count_next = attempt_count;
    store_we           = 1'b0;
    cmd.kind           = CMD_ONE;
    cmd.status         = ST_IGNORED;
    cmd.attempt        = attempt_count;
    cmd.seq            = seq_bit;
    unique case (operation)
      OP_BYTE: begin
        if (!awaiting_ack) begin
          if (fill_count < FILL_W'(CHUNK_BYTES)) begin
            store_we        = 1'b1;
            fill_count_next = fill_count + FILL_W'(1);
            byte_sum_next   = byte_sum + SUM_W'(payload_byte);
          end
          // chunk closes when full or at end of message
          if ((LIM_W'(fill_count_next) >= chunk_limit) || end_of_message) begin
            awaiting_ack_next  = 1'b1;
            final_chunk_next   = end_of_message;
            tick_count_next    = 16'd0;
            attempt_count_next = 16'd1;
            cmd.kind           = CMD_FRAME;
            cmd.status         = ST_SENT;
            cmd.attempt        = 16'd1;
          end else begin
            cmd.status = ST_STORED;
          end
        end
      end
      OP_ACK: begin
        cmd.status = ST_UNEXPECTED;
        if (awaiting_ack) begin
          tick_count_next = 16'd0;
          if (ack_seq == {7'd0, seq_bit}) begin
            awaiting_ack_next  = 1'b0;
            fill_count_next    = '0;
            byte_sum_next      = '0;
            final_chunk_next   = 1'b0;
            attempt_count_next = 16'd0;
            cmd.status         = ST_DELIVERED;
            if (final_chunk) begin
              cmd.kind     = CMD_END;
              seq_bit_next = 1'b0;
            end else begin
              seq_bit_next = !seq_bit;
            end
          end
        end
      end
      OP_TICK: begin
        cmd.status = ST_STORED;
        if (awaiting_ack) begin
          if (tick_inc >= tick_limit) begin
            // timeout: resend the frame
            tick_count_next    = 16'd0;
            attempt_count_next = attempt_inc;
            cmd.kind           = CMD_FRAME;
            cmd.status         = ST_RESENT;
            cmd.attempt        = attempt_inc;
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end
      default: begin
        cmd.status = ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_size    <= 4'd8;
      timeout_ticks <= 16'd3000;
      fill_count    <= '0;
      seq_bit       <= 1'b0;
      awaiting_ack  <= 1'b0;
      final_chunk   <= 1'b0;
      byte_sum      <= '0;
      tick_count    <= 16'd0;
      attempt_count <= 16'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CHUNK_SIZE: chunk_size    <= cfg_data[3:0];
          CFG_TIMEOUT:    timeout_ticks <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        fill_count    <= fill_count_next;
        seq_bit       <= seq_bit_next;
        awaiting_ack  <= awaiting_ack_next;
        final_chunk   <= final_chunk_next;
        byte_sum      <= byte_sum_next;
        tick_count    <= tick_count_next;
        attempt_count <= attempt_count_next;
      end
    end
  end

  // chunk store, written at the fill position, read by the sequencer
  swas_ram #(
    .WIDTH (8),
    .DEPTH (CHUNK_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (accept && store_we),
    .waddr (IDX_W'(fill_count)),
    .wdata (payload_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // frame, END and single-result sequencer with the output register
  swas_tx #(
    .FILL_W (FILL_W),
    .SUM_W  (SUM_W),
    .IDX_W  (IDX_W),
    .NDIG   (NDIG),
    .DIG_W  (DIG_W)
  ) u_tx (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .cmd       (cmd),
    .fill      (fill_count_next),
    .sum       (byte_sum_next),
    .busy      (tx_busy),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

`ifndef SYNTH
  // an accepted transaction must occupy the sequencer
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input accepted while sequencer still free");

  // the tick count only runs while a frame waits
  a_tick_idle: assert property (@(posedge clk) disable iff (rst)
    !awaiting_ack |-> (tick_count == 16'd0))
    else $error("tick count running with no frame outstanding");

  // an outstanding frame always has at least one attempt, none otherwise
  a_attempt_wait: assert property (@(posedge clk) disable iff (rst)
    awaiting_ack == (attempt_count != 16'd0))
    else $error("attempt count inconsistent with ack wait");

  // an open chunk never reaches the store depth
  a_fill_open: assert property (@(posedge clk) disable iff (rst)
    !awaiting_ack |-> (fill_count < FILL_W'(CHUNK_BYTES)))
    else $error("open chunk overfilled");
`endif

endmodule

@@ test/tb_stop_and_wait_arq_sender_top.sv @@
// Self-checking testbench for the stop-and-wait ARQ sender: directed cases, random traffic.
module tb_stop_and_wait_arq_sender_top;
  timeunit 1ns;
  timeprecision 1ps;

  import swas_pkg::*;

  localparam int CHUNK_BYTES = 8;

  localparam int HOLD_CYCLES   = 300;  // length of the one long receiver hold-off
  localparam int SETTLE_CYCLES = 20;   // quiet cycles after the last result before reconfig

  // One result transaction as the block should present it
  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        byte_valid;
    status_t     status;
    logic [15:0] attempt;
    logic        last;
  } tx_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;

  stop_and_wait_arq_sender_top #(.CHUNK_BYTES(CHUNK_BYTES)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial forever #10 clk = ~clk;

  // Results still owed by the block, oldest first
  tx_result_t owed_q[$];
  tx_result_t staged;      // last result of the current input, held back to set its last flag
  logic       staged_ok;
  tx_result_t front;

  // Predictor copy of the sender state and registers
  logic [7:0]  held_bytes [CHUNK_BYTES];
  int          held_count;
  logic        seq_now;
  logic        frame_out;    // a frame is waiting for its ACK
  logic        last_chunk;
  int          chunk_total;
  int          tick_run;
  logic [15:0] attempts_now;
  logic [3:0]  cfg_chunk;
  logic [15:0] cfg_timeout;

  int send_idle_pct;
  int recv_idle_pct;
  logic hold_armed = 1'b0;
  int held_cycles = 0;
  int items_sent;
  int results_seen;
  int mismatches;

  // ------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------
  function automatic void put_result(input logic [7:0] b, input logic v, input status_t st);
    if (staged_ok) owed_q.push_back(staged);
    staged = '{tx_byte: b, byte_valid: v, status: st, attempt: attempts_now, last: 1'b0};
    staged_ok = 1'b1;
  endfunction

  // DATA|s|<chunk>|<decimal sum>\n, one byte per result
  function automatic void put_frame(input status_t st);
    string hdr = "DATA|";
    int    digit_buf [6];
    int    nd;
    int    rest;
    for (int i = 0; i < 5; i++) put_result(hdr[i], 1'b1, st);
    put_result(8'h30 + seq_now, 1'b1, st);
    put_result("|", 1'b1, st);
    for (int i = 0; i < held_count; i++) put_result(held_bytes[i], 1'b1, st);
    put_result("|", 1'b1, st);
    nd = 0;
    rest = chunk_total;
    do begin
      digit_buf[nd] = rest % 10;
      rest = rest / 10;
      nd++;
    end while (rest != 0);
    for (int i = nd - 1; i >= 0; i--) put_result(8'(8'h30 + digit_buf[i]), 1'b1, st);
    put_result(8'h0A, 1'b1, st);
  endfunction

  function automatic void sender_step(input logic [1:0] op, input logic [7:0] pb,
                                      input logic eom, input logic [7:0] ackn);
    int lim;
    staged_ok = 1'b0;
    case (op)
      OP_BYTE: begin
        if (frame_out) begin
          put_result(8'h00, 1'b0, ST_IGNORED);
        end else begin
          lim = (cfg_chunk == 0) ? 1 : (cfg_chunk > CHUNK_BYTES) ? CHUNK_BYTES : cfg_chunk;
          if (held_count < CHUNK_BYTES) begin
            held_bytes[held_count] = pb;
            held_count++;
            chunk_total += pb;
          end
          if (held_count >= lim || eom) begin
            frame_out = 1'b1;
            last_chunk = eom;
            tick_run = 0;
            attempts_now = 16'd1;
            put_frame(ST_SENT);
          end else begin
            put_result(8'h00, 1'b0, ST_STORED);
          end
        end
      end
      OP_ACK: begin
        if (!frame_out) begin
          put_result(8'h00, 1'b0, ST_UNEXPECTED);
        end else begin
          tick_run = 0;
          if (ackn == {7'd0, seq_now}) begin
            frame_out = 1'b0;
            held_count = 0;
            chunk_total = 0;
            if (last_chunk) begin
              put_result("E", 1'b1, ST_DELIVERED);
              put_result("N", 1'b1, ST_DELIVERED);
              put_result("D", 1'b1, ST_DELIVERED);
              put_result(8'h0A, 1'b1, ST_DELIVERED);
              seq_now = 1'b0;
            end else begin
              put_result(8'h00, 1'b0, ST_DELIVERED);
              seq_now = ~seq_now;
            end
            last_chunk = 1'b0;
            attempts_now = 16'd0;
          end else begin
            put_result(8'h00, 1'b0, ST_UNEXPECTED);
          end
        end
      end
      OP_TICK: begin
        if (!frame_out) begin
          put_result(8'h00, 1'b0, ST_STORED);
        end else begin
          lim = (cfg_timeout == 0) ? 1 : cfg_timeout;
          if (tick_run < 16'hFFFF) tick_run++;
          if (tick_run >= lim) begin
            tick_run = 0;
            if (attempts_now != 16'hFFFF) attempts_now++;
            put_frame(ST_RESENT);
          end else begin
            put_result(8'h00, 1'b0, ST_STORED);
          end
        end
      end
      default: put_result(8'h00, 1'b0, ST_IGNORED);
    endcase
    staged.last = 1'b1;
    owed_q.push_back(staged);
  endfunction

  // ------------------------------------------------------------------
  // Input side
  // ------------------------------------------------------------------
  // Offers one item, with a random gap first; prediction runs at the accepting edge.
  // s_tvalid stays high after acceptance so back-to-back items need no second assignment.
  task automatic send_item(input logic [1:0] op, input logic [7:0] pb,
                           input logic eom, input logic [7:0] ackn);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {ackn, pb};
    s_tlast  <= eom;
    do @(posedge clk); while (!s_tready);
    sender_step(op, pb, eom, ackn);
    items_sent++;
  endtask

  // Unused fields carry random values so every input bit toggles
  task automatic send_byte(input logic [7:0] pb, input logic eom);
    send_item(OP_BYTE, pb, eom, 8'($urandom_range(255)));
  endtask

  task automatic send_ack(input logic [7:0] ackn);
    send_item(OP_ACK, 8'($urandom_range(255)), 1'($urandom_range(1)), ackn);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
              8'($urandom_range(255)));
  endtask

  // Stop offering and wait until every owed result has left the block
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (owed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers back to back while the block is quiet
  task automatic configure(input logic [3:0] chunk, input logic [15:0] ticks);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CHUNK_SIZE;
    cfg_data  <= {12'($urandom_range(4095)), chunk};
    do @(posedge clk); while (!cfg_ready);
    cfg_chunk = chunk;
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= ticks;
    do @(posedge clk); while (!cfg_ready);
    cfg_timeout = ticks;
    cfg_valid <= 1'b0;
  endtask

  // ------------------------------------------------------------------
  // Output side
  // ------------------------------------------------------------------
  // Random back-pressure, plus the single long hold-off counted here
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_armed && held_cycles < HOLD_CYCLES) begin
      m_tready <= 1'b0;
      held_cycles <= held_cycles + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every result transaction is matched against the oldest owed one
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (owed_q.size() == 0) begin
        $error("unexpected result transaction: tx_byte %h status %0d", m_tdata[7:0],
               m_tuser[3:1]);
        mismatches++;
      end else begin
        front = owed_q.pop_front();
        if (m_tdata[7:0] !== front.tx_byte) begin
          $error("tx_byte: expected %h, got %h", front.tx_byte, m_tdata[7:0]);
          mismatches++;
        end
        if (m_tuser[0] !== front.byte_valid) begin
          $error("byte_valid: expected %b, got %b", front.byte_valid, m_tuser[0]);
          mismatches++;
        end
        if (m_tuser[3:1] !== front.status) begin
          $error("status: expected %0d, got %0d", front.status, m_tuser[3:1]);
          mismatches++;
        end
        if (m_tdata[23:8] !== front.attempt) begin
          $error("attempt: expected %0d, got %0d", front.attempt, m_tdata[23:8]);
          mismatches++;
        end
        if (m_tlast !== front.last) begin
          $error("last_of_run: expected %b, got %b", front.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  // ACK, tick and the unused operation with no frame outstanding
  task automatic test_idle_inputs();
    send_ack(8'd0);
    send_tick();
    send_item(OP_UNUSED, 8'hA5, 1'b1, 8'h5A);
  endtask

  // Three-byte message closed by end of message, with stray inputs while waiting
  task automatic test_short_message();
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);  // zero byte is framed like any other
    send_byte(8'hFF, 1'b1);
    send_byte(8'h55, 1'b0);  // dropped: frame outstanding
    send_ack(8'hFF);         // wrong number
    send_ack(8'd1);
    send_tick();             // well short of the 3000-tick timeout
    send_ack(8'd0);          // delivers the final chunk, END goes out
  endtask

  // Chunk size and timeout of zero behave as one; resends bump the attempt count
  task automatic test_timeouts();
    configure(4'd0, 16'd0);
    send_byte(8'h80, 1'b0);
    send_tick();
    send_tick();
    send_ack(8'd0);          // delivered, sequence bit flips
    send_byte(8'h7F, 1'b1);
    send_ack(8'd0);          // stale number
    send_ack(8'd1);
  endtask

  // Oversized chunk setting clamps to the store depth; largest possible sum
  task automatic test_full_chunk();
    configure(4'd15, 16'hFFFF);
    for (int i = 0; i < CHUNK_BYTES; i++) send_byte(8'hFF, 1'b0);
    send_ack(8'd0);
  endtask

  // One message with random content; while a frame is out, a mix of ticks,
  // right and wrong ACKs, stray bytes and unused operations until delivery
  task automatic send_message(input int max_len);
    int len;
    int pick;
    len = $urandom_range(max_len, 1);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), i == len - 1);
      while (frame_out) begin
        pick = $urandom_range(99);
        if (pick < 40)      send_ack({7'd0, seq_now});
        else if (pick < 68) send_tick();
        else if (pick < 82) send_ack(8'($urandom_range(255)));
        else if (pick < 92) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        else                send_item(OP_UNUSED, 8'($urandom_range(255)),
                                      1'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_random_traffic(input int quota);
    int stop_at;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) == 0) begin
        // noise between messages
        if ($urandom_range(1) == 0) send_ack(8'($urandom_range(255)));
        else                        send_tick();
      end else begin
        send_message(12);
      end
    end
  endtask

  // Receiver stops for a long stretch while a frame and then ticks keep coming
  task automatic test_output_backpressure();
    configure(4'd8, 16'd1000);
    hold_armed <= 1'b1;
    for (int i = 0; i < CHUNK_BYTES; i++) send_byte(8'($urandom_range(255)), 1'b0);
    repeat (16) send_tick();
    send_ack({7'd0, seq_now});
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    cfg_valid <= 1'b0;
    cfg_index <= CFG_CHUNK_SIZE;
    cfg_data  <= 16'd0;
    s_tvalid  <= 1'b0;
    s_tdata   <= 16'd0;
    s_tuser   <= OP_BYTE;
    s_tlast   <= 1'b0;
    held_count   = 0;
    seq_now      = 1'b0;
    frame_out    = 1'b0;
    last_chunk   = 1'b0;
    chunk_total  = 0;
    tick_run     = 0;
    attempts_now = 16'd0;
    cfg_chunk    = 4'd8;
    cfg_timeout  = 16'd3000;
    items_sent   = 0;
    results_seen = 0;
    mismatches   = 0;

    // phase 1: sender gaps 31 %, receiver stalls 70 %
    send_idle_pct = 31;
    recv_idle_pct = 70;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_idle_inputs();
    test_short_message();
    test_timeouts();
    test_full_chunk();
    configure(4'd3, 16'd4);
    test_random_traffic(60);

    // phase 2: roles swapped, full-size chunks and frequent resends
    configure(4'd8, 16'd2);
    send_idle_pct = 70;
    recv_idle_pct = 31;
    test_random_traffic(60);

    // phase 3: no idling on either side
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    configure(4'd1, 16'hFFFF);
    test_random_traffic(20);
    configure(4'd5, 16'd1);
    test_random_traffic(20);

    wait_idle();
    $display("Sent %0d input transactions and checked %0d result transactions.",
             items_sent, results_seen);
    $display("Covered chunk sizes 0 to 15, timeouts 0 to 65535, resends and a long stall.");
    if (mismatches == 0 && owed_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
